// ----- sv/ttq_pkg.sv -----
// ttq_pkg: shared types and constants for the timed task queue.
// No dependencies.
`default_nettype none
package ttq_pkg;
   localparam int MaxOut = 16;

   typedef enum logic [1:0] {
      MODE_SCHED  = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SCHED  = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TASK   = 2'd2,
      KIND_RSVD   = 2'd3
   } kind_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] delay_ms;
      logic        immediate;
      logic [15:0] task_tag;
      logic [31:0] cancel_handle;
   } cmd_type;
endpackage
`default_nettype wire

// ----- sv/ttq_front.sv -----
// ttq_front: accepts items, drops unused modes, and feeds a two-entry command queue.
// Depends on ttq_pkg.
`default_nettype none
module ttq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ttq_pkg::cmd_type cmd,
   output logic                  q_valid,
   output ttq_pkg::cmd_type      q_cmd,
   input  wire logic             q_pop
);
   import ttq_pkg::*;
   cmd_type    q_ff [2];
   cmd_type    q_in0, q_in1;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy && (cmd.mode != MODE_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = q_ff[0];

   always_comb begin
      q_in0  = q_ff[0];
      q_in1  = q_ff[1];
      cnt_in = cnt_ff;
      if (q_pop && q_valid) begin
         q_in0  = q_ff[1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) q_in0 = cmd;
         else                q_in1 = cmd;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in0;
      q_ff[1] <= q_in1;
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// ----- sv/ttq_back.sv -----
// ttq_back: holds the task table and executes commands by scanning one slot a cycle.
// Depends on ttq_pkg.
`default_nettype none
module ttq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire ttq_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [31:0]           rsp_handle,
   output logic [15:0]           rsp_tag_out,
   output logic                  rsp_ok,
   output logic                  rsp_last
);
   import ttq_pkg::*;
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = $clog2(MaxOut + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_EMIT = 5'b00100,
      ST_PEND = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   logic [QUEUE_DEPTH-1:0] vld_ff, vld_in;
   logic [47:0] dl_ff  [QUEUE_DEPTH];
   logic [31:0] hd_ff  [QUEUE_DEPTH];
   logic [15:0] tg_ff  [QUEUE_DEPTH];

   state_type   st_ff, st_in;
   cmd_type     c_ff, c_in;
   logic [CW-1:0] i_ff, i_in;
   logic [IW-1:0] idx;
   logic [31:0] cnt_ff, cnt_in;
   logic [47:0] now_ff, now_in;
   logic        fnd_ff, fnd_in;
   logic [IW-1:0] bi_ff, bi_in;
   logic [47:0] bd_ff, bd_in;
   logic [31:0] bh_ff, bh_in;
   logic [NW-1:0] n_ff, n_in;
   logic        pv_ff, pv_in;
   logic [31:0] ph_ff, ph_in;
   logic [15:0] pt_ff, pt_in;
   logic        wr;
   logic [IW-1:0] wi;
   logic [47:0] wd;
   logic        ov_ff, ov_in;
   logic [1:0]  ok_kind_ff, ok_kind_in;
   logic [31:0] oh_ff, oh_in;
   logic [15:0] ot_ff, ot_in;
   logic        ook_ff, ook_in, ol_ff, ol_in;
   logic        better;

   assign idx = i_ff[IW-1:0];
   assign rsp_valid   = ov_ff;
   assign rsp_kind    = ok_kind_ff;
   assign rsp_handle  = oh_ff;
   assign rsp_tag_out = ot_ff;
   assign rsp_ok      = ook_ff;
   assign rsp_last    = ol_ff;

   always_comb begin
      better = !fnd_ff || (dl_ff[idx] < bd_ff) ||
               ((dl_ff[idx] == bd_ff) && (hd_ff[idx] < bh_ff));
   end

   always_comb begin
      st_in = st_ff; c_in = c_ff; i_in = i_ff; cnt_in = cnt_ff; now_in = now_ff;
      fnd_in = fnd_ff; bi_in = bi_ff; bd_in = bd_ff; bh_in = bh_ff; n_in = n_ff;
      pv_in = pv_ff; ph_in = ph_ff; pt_in = pt_ff; vld_in = vld_ff;
      wr = 1'b0; wi = idx; wd = '0; q_pop = 1'b0;
      ov_in = 1'b0; ok_kind_in = ok_kind_ff; oh_in = oh_ff; ot_in = ot_ff;
      ook_in = ook_ff; ol_in = ol_ff;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1; c_in = q_cmd; i_in = '0; fnd_in = 1'b0;
               n_in = '0; pv_in = 1'b0; st_in = ST_SCAN;
               if (q_cmd.mode == MODE_TICK) now_in = now_ff + 48'd1;
            end
         end
         ST_SCAN: begin
            if (i_ff == CW'(QUEUE_DEPTH)) begin
               st_in = ST_EMIT;
            end else begin
               i_in = i_ff + CW'(1);
               case (c_ff.mode)
                  MODE_SCHED: if (!vld_ff[idx] && !fnd_ff) begin
                     fnd_in = 1'b1; bi_in = idx;
                  end
                  MODE_CANCEL: if (vld_ff[idx] && !fnd_ff &&
                                   hd_ff[idx] == c_ff.cancel_handle) begin
                     fnd_in = 1'b1; bi_in = idx;
                  end
                  default: if (vld_ff[idx] && dl_ff[idx] <= now_ff && better) begin
                     fnd_in = 1'b1; bi_in = idx; bd_in = dl_ff[idx]; bh_in = hd_ff[idx];
                  end
               endcase
            end
         end
         ST_EMIT: begin
            case (c_ff.mode)
               MODE_SCHED: begin
                  ov_in = 1'b1; ok_kind_in = KIND_SCHED; ot_in = '0; ol_in = 1'b1;
                  ook_in = fnd_ff; oh_in = '0;
                  if (fnd_ff) begin
                     cnt_in = cnt_ff + 32'd1; oh_in = cnt_ff + 32'd1;
                     vld_in[bi_ff] = 1'b1; wr = 1'b1; wi = bi_ff;
                     wd = c_ff.immediate ? 48'd0 : now_ff + {16'd0, c_ff.delay_ms};
                  end
                  st_in = ST_IDLE;
               end
               MODE_CANCEL: begin
                  ov_in = 1'b1; ok_kind_in = KIND_CANCEL; ot_in = '0; ol_in = 1'b1;
                  ook_in = fnd_ff; oh_in = c_ff.cancel_handle;
                  if (fnd_ff) vld_in[bi_ff] = 1'b0;
                  st_in = ST_IDLE;
               end
               default: begin
                  if (fnd_ff) begin
                     if (pv_ff) begin
                        ov_in = 1'b1; ok_kind_in = KIND_TASK; oh_in = ph_ff;
                        ot_in = pt_ff; ook_in = 1'b1; ol_in = 1'b0;
                     end
                     pv_in = 1'b1; ph_in = hd_ff[bi_ff]; pt_in = tg_ff[bi_ff];
                     vld_in[bi_ff] = 1'b0; n_in = n_ff + NW'(1);
                     if (n_ff + NW'(1) == NW'(MaxOut)) st_in = ST_DONE;
                     else begin
                        i_in = '0; fnd_in = 1'b0; st_in = ST_SCAN;
                     end
                  end else st_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (pv_ff) begin
               ov_in = 1'b1; ok_kind_in = KIND_TASK; oh_in = ph_ff; ot_in = pt_ff;
               ook_in = 1'b1; ol_in = 1'b1;
            end
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         dl_ff[wi] <= wd;
         hd_ff[wi] <= cnt_ff + 32'd1;
         tg_ff[wi] <= c_ff.task_tag;
      end
      c_ff <= c_in; i_ff <= i_in; fnd_ff <= fnd_in; bi_ff <= bi_in;
      bd_ff <= bd_in; bh_ff <= bh_in; n_ff <= n_in; ph_ff <= ph_in; pt_ff <= pt_in;
      ok_kind_ff <= ok_kind_in; oh_ff <= oh_in; ot_ff <= ot_in;
      ook_ff <= ook_in; ol_ff <= ol_in;
      if (reset) begin
         st_ff <= ST_IDLE; vld_ff <= '0; cnt_ff <= '0; now_ff <= '0;
         pv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; cnt_ff <= cnt_in; now_ff <= now_in;
         pv_ff <= pv_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

// ----- sv/timed_task_queue.sv -----
// timed_task_queue: top level, front command queue plus back execution engine.
// Depends on ttq_pkg, ttq_front, ttq_back.
//
// Usage: drive req_* with start high; the item is taken at an edge where busy
// is low. mode 0 schedules a task and returns one schedule ack with its new
// handle (ok 0 when full). mode 1 cancels by handle, one ack. mode 2 advances
// the millisecond clock and dispatches each due task, earliest deadline then
// handle first, up to 16, the final one marked rsp_last. mode 3 is dropped.
// Results appear for one cycle with rsp_valid; the receiver cannot stall.
// Schedule and cancel each run one full slot scan, which reads one table entry
// per cycle. A tick runs one full scan per dispatched task to find the minimum.
// A two-item command queue lets busy stay low while the engine works, until two items wait.
// Reset (synchronous) empties the queue, clears all slots, handle counter
// and time.
`default_nettype none
module timed_task_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_delay_ms,
   input  wire logic        req_immediate,
   input  wire logic [15:0] req_task_tag,
   input  wire logic [31:0] req_cancel_handle,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_handle,
   output logic [15:0]      rsp_tag_out,
   output logic             rsp_ok,
   output logic             rsp_last
);
   import ttq_pkg::*;
   cmd_type cmd, q_cmd;
   logic    q_valid, q_pop;

   assign cmd.mode          = mode_type'(req_mode);
   assign cmd.delay_ms      = req_delay_ms;
   assign cmd.immediate     = req_immediate;
   assign cmd.task_tag      = req_task_tag;
   assign cmd.cancel_handle = req_cancel_handle;

   ttq_front u_front (
      .clock, .reset, .start, .busy, .cmd,
      .q_valid, .q_cmd, .q_pop
   );

   ttq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop,
      .rsp_valid, .rsp_kind, .rsp_handle, .rsp_tag_out, .rsp_ok, .rsp_last
   );
endmodule
`default_nettype wire

// ----- tb/ttq_checker.sv -----
// ttq_checker: watches the command and result ports of timed_task_queue,
// models the task table and compares every result. Depends on ttq_pkg.
`timescale 1ns / 100ps
module ttq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_delay_ms,
   input  logic        req_immediate,
   input  logic [15:0] req_task_tag,
   input  logic [31:0] req_cancel_handle,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_handle,
   input  logic [15:0] rsp_tag_out,
   input  logic        rsp_ok,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          dispatched
);
   import ttq_pkg::*;

   localparam int Slots = 16;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] handle;
      logic [15:0] tag;
      logic        ok;
      logic        last;
   } rsp_type;

   logic        slot_used [Slots];
   logic [47:0] slot_due [Slots];
   logic [31:0] slot_handle [Slots];
   logic [15:0] slot_tag [Slots];
   logic [31:0] handle_count;
   logic [47:0] now_ms;
   rsp_type     expected_rsps[$];

   function automatic rsp_type mk(kind_type k, logic [31:0] h, logic [15:0] t,
                                  logic ok, logic last);
      rsp_type r;
      r.kind = k; r.handle = h; r.tag = t; r.ok = ok; r.last = last;
      return r;
   endfunction

   task automatic predict_cmd(logic [1:0] mode, logic [31:0] dly, logic imm,
                              logic [15:0] tag, logic [31:0] ch);
      int  best;
      int  n;
      bit  done;
      done = 0;
      case (mode)
         MODE_SCHED: begin
            for (int i = 0; i < Slots; i++)
               if (!done && !slot_used[i]) begin
                  handle_count++;
                  slot_used[i] = 1;
                  slot_due[i] = imm ? 48'd0 : now_ms + {16'd0, dly};
                  slot_handle[i] = handle_count;
                  slot_tag[i] = tag;
                  expected_rsps.push_back(mk(KIND_SCHED, handle_count, 0, 1, 1));
                  done = 1;
               end
            if (!done) expected_rsps.push_back(mk(KIND_SCHED, 0, 0, 0, 1));
         end
         MODE_CANCEL: begin
            for (int i = 0; i < Slots; i++)
               if (!done && slot_used[i] && slot_handle[i] == ch) begin
                  slot_used[i] = 0;
                  done = 1;
               end
            expected_rsps.push_back(mk(KIND_CANCEL, ch, 0, done, 1));
         end
         MODE_TICK: begin
            now_ms++;
            n = 0;
            while (n < MaxOut) begin
               best = -1;
               for (int i = 0; i < Slots; i++)
                  if (slot_used[i] && slot_due[i] <= now_ms)
                     if (best < 0 || slot_due[i] < slot_due[best] ||
                         (slot_due[i] == slot_due[best] &&
                          slot_handle[i] < slot_handle[best]))
                        best = i;
               if (best < 0) break;
               slot_used[best] = 0;
               expected_rsps.push_back(mk(KIND_TASK, slot_handle[best],
                                          slot_tag[best], 1, 0));
               n++;
            end
            if (n > 0) expected_rsps[$].last = 1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type exp_r;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] <= 0;
         handle_count <= 0;
         now_ms <= 0;
         expected_rsps.delete();
         fail_count <= 0;
         dispatched <= 0;
      end else begin
         if (rsp_valid) begin
            got = mk(kind_type'(rsp_kind), rsp_handle, rsp_tag_out, rsp_ok, rsp_last);
            if (rsp_kind == KIND_TASK) dispatched <= dispatched + 1;
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got !== exp_r) begin
                  if (fail_count < 10)
                     $display("mismatch at %0t: expected %p, got %p", $time, exp_r, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            predict_cmd(req_mode, req_delay_ms, req_immediate, req_task_tag,
                        req_cancel_handle);
      end
   end

   assign pending = expected_rsps.size();
endmodule

// ----- tb/tb_timed_task_queue.sv -----
// tb_timed_task_queue: drives directed items, then schedule, cancel, tick and dropped items into the task
// queue in random bursts. Depends on ttq_pkg, ttq_checker and the block.
`timescale 1ns / 100ps
module tb_timed_task_queue;
   import ttq_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_mode = MODE_NONE;
   logic [31:0] req_delay_ms = 0;
   logic        req_immediate = 0;
   logic [15:0] req_task_tag = 0;
   logic [31:0] req_cancel_handle = 0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_handle;
   logic [15:0] rsp_tag_out;
   logic        rsp_ok;
   logic        rsp_last;
   int          fail_count;
   int          pending;
   int          dispatched;
   int          sent;
   logic [31:0] last_handle;

   always #2 clock = ~clock;

   timed_task_queue dut (.*);

   ttq_checker checker_i (.*);

   // start stays high on return; the caller drops it before idling
   task automatic send(mode_type m, logic [31:0] dly, logic imm, logic [15:0] tag,
                       logic [31:0] ch);
      req_mode <= m; req_delay_ms <= dly; req_immediate <= imm;
      req_task_tag <= tag; req_cancel_handle <= ch; start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      sent++;
      if (m == MODE_SCHED) last_handle = last_handle + 1;
   endtask

   task automatic drain();
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   initial begin
      int gap;
      int burst;
      int r;
      sent = 0;
      last_handle = 0;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: extremes, fill to full, cancels, tick with 15 due
      send(MODE_TICK, 0, 0, 0, 0);
      send(MODE_SCHED, 32'hFFFF_FFFF, 0, 16'hFFFF, 32'hFFFF_FFFF);
      send(MODE_SCHED, 0, 1, 16'h0000, 0);
      send(MODE_SCHED, 1, 0, 16'hA5A5, 0);
      send(MODE_CANCEL, 0, 1, 16'hFFFF, 32'd2);
      send(MODE_CANCEL, 0, 0, 0, 32'd2);
      send(MODE_CANCEL, 0, 0, 0, 32'hFFFF_FFFF);
      send(MODE_NONE, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 15; i++) send(MODE_SCHED, 1, i[0], 16'(i), 0);
      send(MODE_SCHED, 0, 0, 16'h1234, 0);
      send(MODE_TICK, 0, 0, 0, 0);
      send(MODE_TICK, 0, 0, 0, 0);
      drain();
      // random: mostly small delays, cancels aimed at recent handles
      while (sent < 320) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
               send(MODE_SCHED, ($urandom_range(0, 15) == 0) ? $urandom
                    : $urandom_range(0, 6), $urandom_range(0, 7) == 0,
                    16'($urandom), 0);
            else if (r < 55)
               send(MODE_CANCEL, $urandom, $urandom_range(0, 1), 16'($urandom),
                    ($urandom_range(0, 4) == 0) ? $urandom
                    : last_handle - $urandom_range(0, 8));
            else if (r < 97)
               send(MODE_TICK, $urandom, $urandom_range(0, 1), 16'($urandom), $urandom);
            else
               send(MODE_NONE, $urandom, $urandom_range(0, 1), 16'($urandom), $urandom);
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge clock);
         end
         if (sent > 150 && sent < 165) drain();
      end
      drain();
      $display("covered %0d items, %0d tasks dispatched, full queue and cancels",
               sent, dispatched);
      if (fail_count == 0)
         $display("[timed_task_queue] OK");
      else
         $display("[timed_task_queue] ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("[timed_task_queue] ERROR");
      $finish;
   end
endmodule
